// ===== rtl/quantum_gate_unitary_fusion_assert.svh =====
// Assertion macros for the unitary gate fusion block.
`ifndef QUANTUM_GATE_UNITARY_FUSION_ASSERT_SVH
`define QUANTUM_GATE_UNITARY_FUSION_ASSERT_SVH

// Immediate implication, checked on every clock edge out of reset.
`define QGUF_ASSERT_NOW(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define QGUF_ASSERT_NEXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);

`endif

// ===== rtl/qguf_pkg.sv =====
// Shared types and constants of the unitary gate fusion block.
package qguf_pkg;

  localparam int MAX_QUBITS_DEF = 3;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int DATA_W         = 16;
  localparam int ACC_W          = 40;
  localparam int NQ_W           = 3;

  typedef struct packed {
    logic store_wr;
    logic store_clr;
    logic set_drop;
    logic clr_drop;
    logic mem_rd;
    logic col_cap;
    logic mul;
    logic acc;
    logic acc_first;
    logic mem_wr;
    logic out_load;
    logic out_last;
    logic ident;
  } cmd_t;

endpackage

// ===== rtl/quantum_gate_unitary_fusion.sv =====
// Top level of the unitary gate fusion block.
// Usage:
//  s_axis carries one item per gate matrix entry; tuser flags say whether it writes
//  the gate store and whether it closes the gate; tlast closes the program.
//  m_axis returns the fused D x D matrix row by row, tlast on the last entry,
//  tuser set when a gate with bad qubit indices was dropped since the last emit.
//  cfg_* writes num_qubits (D = 2^n); write it only while the block is idle.
//  Plain entry items are accepted while idle. Closing a gate sweeps the matrix
//  column by column: each column is loaded from the matrix memory (read, capture
//  per row), then each row takes J products (J = 2 or 4 gate columns), each a
//  multiply and an accumulate step on the single complex MAC, and a write back.
//  Emission reads each entry through the matrix memory read port, then loads it.
//  s_axis_tready is low while a gate is applied or the matrix is emitted.
//  A stalled receiver holds the emission; the result waits in the output register.
//  Reset loads the identity matrix (per-entry valid bits, no clearing pass),
//  clears the gate store and the drop flag, and sets num_qubits to 3.
module quantum_gate_unitary_fusion #(
  parameter int MAX_QUBITS = qguf_pkg::MAX_QUBITS_DEF,
  parameter int FRAC_BITS  = qguf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,      // num_qubits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // entry_row, entry_col, entry_real, entry_imag,
                                       // qubit_low, qubit_high
  input  logic [2:0]  s_axis_tuser,    // entry_valid, two_qubit, end_of_gate
  input  logic        s_axis_tlast,    // end_of_program
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // out_row, out_col, out_real, out_imag, zero pad
  output logic        m_axis_tuser,    // gate_dropped
  output logic        m_axis_tlast     // last_entry
);

  qguf_pkg::cmd_t        cmd;
  logic [MAX_QUBITS-1:0] row, col;
  logic [1:0]            j, q0, q1;
  logic                  two, out_free;
  logic [2:0]            o_row, o_col;
  logic signed [15:0]    o_re, o_im;

  assign cfg_ready_o = 1'b1;

  qguf_ctrl #(.MAX_QUBITS(MAX_QUBITS)) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .entry_valid_i    (s_axis_tuser[0]),
    .end_of_gate_i    (s_axis_tuser[2]),
    .end_of_program_i (s_axis_tlast),
    .two_qubit_i      (s_axis_tuser[1]),
    .qubit_low_i      (s_axis_tdata[37:36]),
    .qubit_high_i     (s_axis_tdata[39:38]),
    .out_free_i       (out_free),
    .cmd_o            (cmd),
    .row_o            (row),
    .col_o            (col),
    .j_o              (j),
    .two_o            (two),
    .q0_o             (q0),
    .q1_o             (q1)
  );

  qguf_datapath #(.MAX_QUBITS(MAX_QUBITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .row_i          (row),
    .col_i          (col),
    .j_i            (j),
    .two_i          (two),
    .q0_i           (q0),
    .q1_i           (q1),
    .entry_row_i    (s_axis_tdata[1:0]),
    .entry_col_i    (s_axis_tdata[3:2]),
    .entry_real_i   (s_axis_tdata[19:4]),
    .entry_imag_i   (s_axis_tdata[35:20]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_free_o     (out_free),
    .out_row_o      (o_row),
    .out_col_o      (o_col),
    .out_real_o     (o_re),
    .out_imag_o     (o_im),
    .gate_dropped_o (m_axis_tuser),
    .last_entry_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, o_im, o_re, o_col, o_row};

`include "quantum_gate_unitary_fusion_assert.svh"

  `QGUF_ASSERT_NOW(a_last_on_diag, m_axis_tvalid && m_axis_tlast, o_row == o_col, "last entry off diagonal")
  `QGUF_ASSERT_NEXT(a_emit_blocks_in, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during emission")
  `QGUF_ASSERT_NEXT(a_apply_blocks_in, cmd.col_cap || cmd.mul, !s_axis_tready, "input taken during gate apply")

endmodule

// ===== rtl/qguf_ctrl.sv =====
// Controller: sequences gate application and matrix emission.
module qguf_ctrl #(
  parameter int MAX_QUBITS = qguf_pkg::MAX_QUBITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  entry_valid_i,
  input  logic                  end_of_gate_i,
  input  logic                  end_of_program_i,
  input  logic                  two_qubit_i,
  input  logic [1:0]            qubit_low_i,
  input  logic [1:0]            qubit_high_i,
  input  logic                  out_free_i,
  output qguf_pkg::cmd_t        cmd_o,
  output logic [MAX_QUBITS-1:0] row_o,
  output logic [MAX_QUBITS-1:0] col_o,
  output logic [1:0]            j_o,
  output logic                  two_o,
  output logic [1:0]            q0_o,
  output logic [1:0]            q1_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LD_RD, S_LD_CAP, S_MUL, S_ACC, S_WR, S_EM_RD, S_EM_CAP
  } state_e;

  state_e                  state_q;
  logic [1:0]              nq_cfg_q;
  logic [MAX_QUBITS-1:0]   i_q, k_q;
  logic [1:0]              j_q, q0_q, q1_q;
  logic                    two_q, eop_q;
  logic [qguf_pkg::NQ_W-1:0] nq;
  logic [MAX_QUBITS-1:0]   dmax;
  logic [1:0]              jmax;
  logic                    accept, ok, i_last, k_last;

  always_comb begin
    if (nq_cfg_q == 2'd0) begin
      nq = qguf_pkg::NQ_W'(1);
    end else if (qguf_pkg::NQ_W'(nq_cfg_q) > qguf_pkg::NQ_W'(MAX_QUBITS)) begin
      nq = qguf_pkg::NQ_W'(MAX_QUBITS);
    end else begin
      nq = qguf_pkg::NQ_W'(nq_cfg_q);
    end
  end

  assign dmax   = MAX_QUBITS'((MAX_QUBITS + 1)'(1) << nq) - MAX_QUBITS'(1);
  assign jmax   = two_q ? 2'd3 : 2'd1;
  assign i_last = (i_q == dmax);
  assign k_last = (k_q == dmax);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign ok = (qguf_pkg::NQ_W'(qubit_low_i) < nq) &&
              (!two_qubit_i || ((qguf_pkg::NQ_W'(qubit_high_i) < nq) &&
                                (qubit_high_i != qubit_low_i)));

  assign row_o = i_q;
  assign col_o = k_q;
  assign j_o   = j_q;
  assign two_o = two_q;
  assign q0_o  = q0_q;
  assign q1_o  = q1_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.store_wr = accept && entry_valid_i;
        if (accept && end_of_gate_i && !ok) begin
          cmd_o.set_drop  = 1'b1;
          cmd_o.store_clr = 1'b1;
        end
      end
      S_LD_RD:  cmd_o.mem_rd = 1'b1;
      S_LD_CAP: cmd_o.col_cap = 1'b1;
      S_MUL:    cmd_o.mul = 1'b1;
      S_ACC: begin
        cmd_o.acc       = 1'b1;
        cmd_o.acc_first = (j_q == 2'd0);
      end
      S_WR: begin
        cmd_o.mem_wr    = 1'b1;
        cmd_o.store_clr = i_last && k_last;
      end
      S_EM_RD:  cmd_o.mem_rd = 1'b1;
      S_EM_CAP: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = i_last && k_last;
          cmd_o.ident    = i_last && k_last;
          cmd_o.clr_drop = i_last && k_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nq_cfg_q <= 2'd3;
      i_q      <= '0;
      k_q      <= '0;
      j_q      <= '0;
      q0_q     <= '0;
      q1_q     <= '0;
      two_q    <= 1'b0;
      eop_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        nq_cfg_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          i_q <= '0;
          k_q <= '0;
          j_q <= '0;
          if (accept) begin
            two_q <= two_qubit_i;
            q0_q  <= qubit_low_i;
            q1_q  <= qubit_high_i;
            eop_q <= end_of_program_i;
            if (end_of_gate_i && ok) begin
              state_q <= S_LD_RD;
            end else if (end_of_program_i) begin
              state_q <= S_EM_RD;
            end
          end
        end
        S_LD_RD: state_q <= S_LD_CAP;
        S_LD_CAP: begin
          state_q <= S_LD_RD;
          i_q     <= i_q + MAX_QUBITS'(1);
          if (i_last) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (j_q == jmax) begin
            state_q <= S_WR;
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_WR: begin
          j_q <= '0;
          if (!i_last) begin
            i_q     <= i_q + MAX_QUBITS'(1);
            state_q <= S_MUL;
          end else begin
            i_q <= '0;
            if (!k_last) begin
              k_q     <= k_q + MAX_QUBITS'(1);
              state_q <= S_LD_RD;
            end else begin
              k_q     <= '0;
              state_q <= eop_q ? S_EM_RD : S_IDLE;
            end
          end
        end
        S_EM_RD: state_q <= S_EM_CAP;
        S_EM_CAP: begin
          if (out_free_i) begin
            state_q <= S_EM_RD;
            if (!k_last) begin
              k_q <= k_q + MAX_QUBITS'(1);
            end else begin
              k_q <= '0;
              i_q <= i_q + MAX_QUBITS'(1);
              if (i_last) begin
                i_q     <= '0;
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/qguf_datapath.sv =====
// Datapath: gate store, fused matrix memory, complex MAC, output register.
module qguf_datapath #(
  parameter int MAX_QUBITS = qguf_pkg::MAX_QUBITS_DEF,
  parameter int FRAC_BITS  = qguf_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qguf_pkg::cmd_t        cmd_i,
  input  logic [MAX_QUBITS-1:0] row_i,
  input  logic [MAX_QUBITS-1:0] col_i,
  input  logic [1:0]            j_i,
  input  logic                  two_i,
  input  logic [1:0]            q0_i,
  input  logic [1:0]            q1_i,
  input  logic [1:0]            entry_row_i,
  input  logic [1:0]            entry_col_i,
  input  logic signed [15:0]    entry_real_i,
  input  logic signed [15:0]    entry_imag_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_free_o,
  output logic [2:0]            out_row_o,
  output logic [2:0]            out_col_o,
  output logic signed [15:0]    out_real_o,
  output logic signed [15:0]    out_imag_o,
  output logic                  gate_dropped_o,
  output logic                  last_entry_o
);

  localparam int DIM   = 1 << MAX_QUBITS;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = 2 * MAX_QUBITS;
  localparam int DW    = qguf_pkg::DATA_W;
  localparam int AC    = qguf_pkg::ACC_W;
  localparam int ONE_I = (FRAC_BITS >= DW - 1) ? 32767 : (1 << FRAC_BITS);
  localparam logic signed [DW-1:0] ONE = DW'(ONE_I);
  localparam logic signed [AC-1:0] HALF = AC'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [AC-1:0] SMAX = AC'(32767);
  localparam logic signed [AC-1:0] SMIN = -AC'(32768);

  logic signed [DW-1:0] g_re_q [16];
  logic signed [DW-1:0] g_im_q [16];
  logic signed [DW-1:0] c_re_q [DIM];
  logic signed [DW-1:0] c_im_q [DIM];
  logic [2*DW-1:0]      mem_q [DEPTH];
  logic [DEPTH-1:0]     vld_q;
  logic [2*DW-1:0]      rdata_q;
  logic                 rvld_q, rdiag_q, drop_q;
  logic signed [2*DW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [AC-1:0] acc_re_q, acc_im_q, sum_re, sum_im, rx_re, rx_im;
  logic signed [DW-1:0] rd_re, rd_im, w_re, w_im, o_re, o_im, gr, gim;
  logic [AW-1:0]        addr;
  logic [MAX_QUBITS-1:0] m0, m1, sub;
  logic [1:0]           loc;
  logic [3:0]           gidx;

  assign addr = {row_i, col_i};
  assign m0   = MAX_QUBITS'(1) << q0_i;
  assign m1   = MAX_QUBITS'(1) << q1_i;
  assign loc  = {two_i && ((row_i & m1) != '0), (row_i & m0) != '0};
  assign gidx = {loc, j_i};

  always_comb begin
    sub = (row_i & ~m0) | (j_i[0] ? m0 : '0);
    if (two_i) begin
      sub = (sub & ~m1) | (j_i[1] ? m1 : '0);
    end
  end

  assign gr   = g_re_q[gidx];
  assign gim  = g_im_q[gidx];
  assign o_re = c_re_q[sub];
  assign o_im = c_im_q[sub];

  assign rd_re = rvld_q ? rdata_q[DW-1:0] : (rdiag_q ? ONE : '0);
  assign rd_im = rvld_q ? rdata_q[2*DW-1:DW] : '0;

  assign sum_re = AC'(p_rr_q) - AC'(p_ii_q);
  assign sum_im = AC'(p_ri_q) + AC'(p_ir_q);

  function automatic logic signed [DW-1:0] rsat(input logic signed [AC-1:0] x);
    logic signed [AC-1:0] q;
    q = (x + HALF) >>> FRAC_BITS;
    if (q > SMAX) begin
      rsat = DW'(32767);
    end else if (q < SMIN) begin
      rsat = DW'(-32768);
    end else begin
      rsat = q[DW-1:0];
    end
  endfunction

  assign rx_re = acc_re_q;
  assign rx_im = acc_im_q;
  assign w_re  = rsat(rx_re);
  assign w_im  = rsat(rx_im);

  assign out_free_o = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 16; n++) begin
        g_re_q[n] <= '0;
        g_im_q[n] <= '0;
      end
    end else if (cmd_i.store_clr) begin
      for (int n = 0; n < 16; n++) begin
        g_re_q[n] <= '0;
        g_im_q[n] <= '0;
      end
    end else if (cmd_i.store_wr) begin
      g_re_q[{entry_row_i, entry_col_i}] <= entry_real_i;
      g_im_q[{entry_row_i, entry_col_i}] <= entry_imag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.ident) begin
        vld_q <= '0;
      end else if (cmd_i.mem_wr) begin
        vld_q[addr] <= 1'b1;
      end
      if (cmd_i.clr_drop) begin
        drop_q <= 1'b0;
      end else if (cmd_i.set_drop) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[addr] <= {w_im, w_re};
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr];
      rvld_q  <= vld_q[addr];
      rdiag_q <= (row_i == col_i);
    end
    if (cmd_i.col_cap) begin
      c_re_q[row_i] <= rd_re;
      c_im_q[row_i] <= rd_im;
    end
    if (cmd_i.mul) begin
      p_rr_q <= gr * o_re;
      p_ii_q <= gim * o_im;
      p_ri_q <= gr * o_im;
      p_ir_q <= gim * o_re;
    end
    if (cmd_i.acc) begin
      acc_re_q <= cmd_i.acc_first ? sum_re : acc_re_q + sum_re;
      acc_im_q <= cmd_i.acc_first ? sum_im : acc_im_q + sum_im;
    end
    if (cmd_i.out_load) begin
      out_row_o      <= 3'(row_i);
      out_col_o      <= 3'(col_i);
      out_real_o     <= rd_re;
      out_imag_o     <= rd_im;
      gate_dropped_o <= drop_q;
      last_entry_o   <= cmd_i.out_last;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the unitary gate fusion block: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               wr;
    logic               two;
    logic [1:0]         qlo;
    logic [1:0]         qhi;
    logic               eog;
    logic               eop;
  } gate_item_t;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               drop;
    logic               last;
  } fused_entry_t;

  localparam int IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  quantum_gate_unitary_fusion dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int           fm_re [8][8];
  int           fm_im [8][8];
  int           gs_re [16];
  int           gs_im [16];
  bit           drop_flag;
  logic [1:0]   nq_reg;
  fused_entry_t fused_q[$];
  bit           failed;
  bit           rx_burst;
  int           rx_wait;
  int           idle_cycles;
  int           item_count;

  function automatic int round_sat(longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return int'(q);
  endfunction

  function automatic void load_identity();
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        fm_re[r][c] = (r == c) ? 16384 : 0;
        fm_im[r][c] = 0;
      end
  endfunction

  function automatic void apply_gate(int nq, bit two, int q0, int q1);
    int     dim;
    int     nb;
    int     qb[2];
    int     cre[8];
    int     cim[8];
    int     loc;
    int     sub;
    int     gi;
    longint sr;
    longint si;
    dim = 1 << nq;
    nb = two ? 2 : 1;
    qb[0] = q0;
    qb[1] = q1;
    for (int k = 0; k < dim; k++) begin
      for (int i = 0; i < dim; i++) begin
        cre[i] = fm_re[i][k];
        cim[i] = fm_im[i][k];
      end
      for (int i = 0; i < dim; i++) begin
        loc = 0;
        sr = 0;
        si = 0;
        for (int l = 0; l < nb; l++) loc |= ((i >> qb[l]) & 1) << l;
        for (int j = 0; j < (1 << nb); j++) begin
          sub = i;
          gi = ((loc & 3) << 2) | (j & 3);
          for (int l = 0; l < nb; l++)
            if (((j >> l) & 1) != ((i >> qb[l]) & 1)) sub ^= 1 << qb[l];
          sub &= 7;
          sr += longint'(gs_re[gi]) * cre[sub] - longint'(gs_im[gi]) * cim[sub];
          si += longint'(gs_re[gi]) * cim[sub] + longint'(gs_im[gi]) * cre[sub];
        end
        fm_re[i][k] = round_sat(sr);
        fm_im[i][k] = round_sat(si);
      end
    end
  endfunction

  function automatic void predict_item(gate_item_t it);
    int           nq;
    int           dim;
    bit           ok;
    fused_entry_t e;
    nq = (nq_reg == 0) ? 1 : nq_reg;
    if (it.wr) begin
      gs_re[{it.row, it.col}] = it.re;
      gs_im[{it.row, it.col}] = it.im;
    end
    if (it.eog) begin
      ok = it.qlo < nq;
      if (it.two && (it.qhi >= nq || it.qhi == it.qlo)) ok = 0;
      if (ok) apply_gate(nq, it.two, it.qlo, it.qhi);
      else drop_flag = 1;
      for (int i = 0; i < 16; i++) begin
        gs_re[i] = 0;
        gs_im[i] = 0;
      end
    end
    if (it.eop) begin
      dim = 1 << nq;
      for (int r = 0; r < dim; r++)
        for (int c = 0; c < dim; c++) begin
          e.row = 3'(r);
          e.col = 3'(c);
          e.re = fm_re[r][c][15:0];
          e.im = fm_im[r][c][15:0];
          e.drop = drop_flag;
          e.last = (r == dim - 1) && (c == dim - 1);
          fused_q.push_back(e);
        end
      load_identity();
      drop_flag = 0;
    end
  endfunction

  task automatic send_item(gate_item_t it);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.qhi, it.qlo, it.im, it.re, it.col, it.row};
    s_axis_tuser  <= {it.eog, it.two, it.wr};
    s_axis_tlast  <= it.eop;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(it);
    item_count++;
  endtask

  task automatic drain_and_config(logic [1:0] nq);
    s_axis_tvalid <= 1'b0;
    wait (fused_q.size() == 0);
    repeat (800) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= nq;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    nq_reg = nq;
  endtask

  function automatic gate_item_t mk(int row, int col, int re, int im,
                                    int wr, int two, int qlo, int qhi, int eog, int eop);
    gate_item_t it;
    it.row = 2'(row); it.col = 2'(col); it.re = 16'(re); it.im = 16'(im);
    it.wr = wr[0]; it.two = two[0]; it.qlo = 2'(qlo); it.qhi = 2'(qhi);
    it.eog = eog[0]; it.eop = eop[0];
    return it;
  endfunction

  function automatic int rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return ($urandom_range(0, 1) ? 32767 : -32768);
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  // send one gate with random content; some are malformed on purpose
  task automatic random_gate(int nq);
    bit two;
    int qlo;
    int qhi;
    int span;
    two = (nq > 1) ? ($urandom_range(0, 1) != 0) : 1'b0;
    qlo = $urandom_range(0, nq - 1);
    qhi = $urandom_range(0, nq - 1);
    if (two && qhi == qlo) qhi = (qlo + 1) % nq;
    if ($urandom_range(0, 7) == 0) begin
      qlo = $urandom_range(0, 3);
      qhi = $urandom_range(0, 3);
    end
    span = two ? 4 : 2;
    for (int r = 0; r < span; r++)
      for (int c = 0; c < span; c++)
        if ($urandom_range(0, 5) != 0)
          send_item(mk(r, c, rand_val(), rand_val(), 1, two, qlo, qhi, 0, 0));
    if (!two && $urandom_range(0, 2) == 0)
      send_item(mk($urandom_range(2, 3), $urandom_range(0, 3), rand_val(), rand_val(),
                   1, 0, qlo, qhi, 0, 0));
    send_item(mk($urandom_range(0, span - 1), $urandom_range(0, span - 1), rand_val(),
                 rand_val(), $urandom_range(0, 1), two, qlo, qhi, 1,
                 $urandom_range(0, 5) == 0));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      int w;
      w = rx_burst ? $urandom_range(0, 12) : 0;
      rx_wait <= (w > 0) ? w - 1 : 0;
      m_axis_tready <= (w == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        fused_entry_t e;
        if (fused_q.size() == 0) begin
          $error("unexpected result item row=%0d col=%0d",
                 m_axis_tdata[2:0], m_axis_tdata[5:3]);
          failed = 1;
        end else begin
          e = fused_q.pop_front();
          if (m_axis_tdata[2:0] !== e.row) begin
            $error("out_row exp %0d got %0d", e.row, m_axis_tdata[2:0]); failed = 1;
          end
          if (m_axis_tdata[5:3] !== e.col) begin
            $error("out_col exp %0d got %0d", e.col, m_axis_tdata[5:3]); failed = 1;
          end
          if (m_axis_tdata[21:6] !== e.re) begin
            $error("out_real exp %0d got %0d", e.re, $signed(m_axis_tdata[21:6]));
            failed = 1;
          end
          if (m_axis_tdata[37:22] !== e.im) begin
            $error("out_imag exp %0d got %0d", e.im, $signed(m_axis_tdata[37:22]));
            failed = 1;
          end
          if (m_axis_tuser !== e.drop) begin
            $error("gate_dropped exp %0d got %0d", e.drop, m_axis_tuser); failed = 1;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_entry exp %0d got %0d", e.last, m_axis_tlast); failed = 1;
          end
        end
      end
    end
  end

  gate_item_t directed[$];
  logic [1:0] nq_sel;

  initial begin
    idle_cycles = 0;
    failed = 0;
    rx_burst = 1;
    item_count = 0;
    nq_reg = 2'd3;
    drop_flag = 0;
    load_identity();
    for (int i = 0; i < 16; i++) begin
      gs_re[i] = 0;
      gs_im[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity after reset, extremes, all three qubits, bad gates, combined flags
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(mk(0, 0, 32767, -32768, 1, 1, 0, 2, 0, 0));
    directed.push_back(mk(3, 3, -32768, 32767, 1, 1, 0, 2, 0, 0));
    directed.push_back(mk(1, 2, 16384, 0, 1, 1, 0, 2, 0, 0));
    directed.push_back(mk(2, 1, 0, -16384, 1, 1, 0, 2, 1, 0));
    directed.push_back(mk(0, 0, 11585, 0, 1, 0, 2, 0, 0, 0));
    directed.push_back(mk(0, 1, 11585, 0, 1, 0, 2, 0, 0, 0));
    directed.push_back(mk(1, 0, 11585, 0, 1, 0, 2, 0, 0, 0));
    directed.push_back(mk(1, 1, -11585, 0, 1, 0, 2, 0, 0, 0));
    directed.push_back(mk(3, 2, 32767, 32767, 1, 0, 2, 0, 1, 1));
    directed.push_back(mk(0, 0, 16384, 0, 1, 0, 3, 0, 1, 0));
    directed.push_back(mk(0, 0, 16384, 0, 1, 1, 1, 1, 1, 0));
    directed.push_back(mk(0, 0, 16384, 0, 1, 1, 0, 3, 1, 1));
    directed.push_back(mk(1, 1, -32768, -32768, 1, 0, 1, 0, 0, 0));
    directed.push_back(mk(0, 0, -32768, -32768, 1, 0, 1, 0, 0, 0));
    directed.push_back(mk(0, 1, -1, 1, 1, 0, 1, 3, 1, 1));
    foreach (directed[i]) send_item(directed[i]);

    drain_and_config(2'd0);
    send_item(mk(0, 1, 16384, 0, 1, 0, 0, 0, 0, 0));
    send_item(mk(1, 0, 16384, 0, 1, 0, 0, 0, 1, 0));
    send_item(mk(0, 0, 0, 0, 0, 0, 1, 0, 1, 1));

    while (item_count < 150) begin
      nq_sel = 2'($urandom_range(0, 3));
      rx_burst = $urandom_range(0, 3) != 0;
      drain_and_config(nq_sel);
      repeat ($urandom_range(1, 3))
        random_gate((nq_sel == 0) ? 1 : nq_sel);
      send_item(mk($urandom_range(0, 3), $urandom_range(0, 3), rand_val(), rand_val(),
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3),
                   $urandom_range(0, 3), 0, 1));
    end
    drain_and_config(2'd3);
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));

    s_axis_tvalid <= 1'b0;
    wait (fused_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== quantum_gate_unitary_fusion.f =====
+incdir+rtl
rtl/qguf_pkg.sv
rtl/qguf_ctrl.sv
rtl/qguf_datapath.sv
rtl/quantum_gate_unitary_fusion.sv
verif/tb_top.sv
